[rtl/header_token_search_core_assert.svh]
// Assertion helpers used by header_token_search_core.sv.
`ifndef HEADER_TOKEN_SEARCH_CORE_ASSERT_SVH
`define HEADER_TOKEN_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define HTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hts assertion failed");

// Next-cycle implication, off while reset is held.
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hts assertion failed");

`endif

[rtl/hts_pkg.sv]
`default_nettype none
package hts_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // characters held by one pair of 64-bit registers
    localparam int REG_CHARS  = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOK_LO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOK_HI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOK_LEN  = 3'd5;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] lc_byte;
    } t_chain_ctl;

    typedef struct packed {
        logic valid;
        logic found;
    } t_result;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/hts_if.sv]
`default_nettype none
interface hts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hts_result_if;
    logic valid;
    logic ready;
    logic token_found;
    modport source (output valid, output token_found, input ready);
    modport sink (input valid, input token_found, output ready);
endinterface

interface hts_cfg_if;
    import hts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/header_token_search_core.sv]
// Channel   Dir  Fields                   Transaction
// i_cfg     in   index, data              register write, always ready
// i_byte    in   data_byte, last_byte     one header byte
// o_result  out  token_found              one flag per header block
//
// One byte per cycle while the output queue has room; the token compare is a chain of TOKEN_MAX
// cells that each advance one position per value byte.
// The flag of the final byte is registered into the two-entry output queue.
// i_byte stalls only while both queue entries wait on o_result.
// Reset (synchronous, active low) clears registers, line state and chain.
`default_nettype none
`include "header_token_search_core_assert.svh"
module header_token_search_core #(
    parameter int NAME_MAX  = 16,
    parameter int TOKEN_MAX = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hts_cfg_if.sink       i_cfg,
    hts_byte_if.sink      i_byte,
    hts_result_if.source  o_result
);
    import hts_pkg::*;

    logic [CFG_DATA_W-1:0] r_name_lo, r_name_hi, r_tok_lo, r_tok_hi;
    logic [LEN_W-1:0]      r_name_len, r_tok_len;

    logic [8*REG_CHARS-1:0] w_tok_word;
    logic                   w_acc;
    logic                   w_hit;
    logic [TOKEN_MAX-1:0]   w_hits;
    logic [TOKEN_MAX:0]     w_match;
    t_chain_ctl             w_ctl;
    t_result                w_res;

    logic r_out_valid, r_out_found;
    logic r_sk_valid, r_sk_found;
    logic w_take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_lo  <= '0;
            r_name_hi  <= '0;
            r_name_len <= '0;
            r_tok_lo   <= '0;
            r_tok_hi   <= '0;
            r_tok_len  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NAME_LO:  r_name_lo  <= i_cfg.data;
                REG_NAME_HI:  r_name_hi  <= i_cfg.data;
                REG_NAME_LEN: r_name_len <= i_cfg.data[LEN_W-1:0];
                REG_TOK_LO:   r_tok_lo   <= i_cfg.data;
                REG_TOK_HI:   r_tok_hi   <= i_cfg.data;
                REG_TOK_LEN:  r_tok_len  <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_byte.ready = !r_sk_valid;
    assign w_acc        = i_byte.valid && !r_sk_valid;
    assign w_tok_word   = {r_tok_hi, r_tok_lo};

    hts_ctrl #(
        .NAME_MAX (NAME_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_data      (i_byte.data_byte),
        .i_last      (i_byte.last_byte),
        .i_name_word ({r_name_hi, r_name_lo}),
        .i_name_len  (r_name_len),
        .i_tok_empty (r_tok_len == '0),
        .i_hit       (w_hit),
        .o_ctl       (w_ctl),
        .o_res       (w_res)
    );

    assign w_match[0] = 1'b1;

    for (genvar k = 0; k < TOKEN_MAX; k++) begin : g_cell
        logic [7:0] w_tok_char;
        if (k < REG_CHARS) begin : g_reg
            assign w_tok_char = to_lower(w_tok_word[8*k +: 8]);
        end else begin : g_zero
            assign w_tok_char = 8'h00;
        end
        hts_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_tok_char (w_tok_char),
            .i_is_last  (32'(r_tok_len) == k + 1),
            .i_prev     (w_match[k]),
            .o_match    (w_match[k+1]),
            .o_hit      (w_hits[k])
        );
    end

    assign w_hit = |w_hits;

    // two-entry result queue: head drives o_result, second entry absorbs a stall
    assign w_take = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            priority if (w_take && w_res.valid) begin
                if (r_sk_valid) begin
                    r_out_found <= r_sk_found;
                    r_sk_found  <= w_res.found;
                end else begin
                    r_out_found <= w_res.found;
                end
            end else if (w_take) begin
                r_out_valid <= r_sk_valid;
                r_out_found <= r_sk_found;
                r_sk_valid  <= 1'b0;
            end else if (w_res.valid) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_found <= w_res.found;
                end else begin
                    r_sk_valid <= 1'b1;
                    r_sk_found <= w_res.found;
                end
            end else begin
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.token_found = r_out_found;

    `HTS_ASSERT_NOW(a_skid_behind_head, i_clk, i_rst_n, r_sk_valid, r_out_valid)
    `HTS_ASSERT_NEXT(a_final_byte_shows, i_clk, i_rst_n, w_acc && i_byte.last_byte, r_out_valid)
    `HTS_ASSERT_NEXT(a_drain_moves_up, i_clk, i_rst_n, w_take && !w_res.valid && r_sk_valid, r_out_valid && !r_sk_valid)
    `HTS_ASSERT_NOW(a_chain_head_set, i_clk, i_rst_n, w_ctl.shift, w_match[0] && !w_ctl.clear || w_ctl.clear)

endmodule
`default_nettype wire

[rtl/hts_cell.sv]
`default_nettype none
// One position of the token match chain: holds whether the token prefix
// ending at this position matched the latest value bytes.
module hts_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire hts_pkg::t_chain_ctl i_ctl,
    input  wire logic [7:0]          i_tok_char,
    input  wire logic                i_is_last,
    input  wire logic                i_prev,
    output logic                     o_match,
    output logic                     o_hit
);
    import hts_pkg::*;

    logic r_match;
    logic n_match;

    assign n_match = i_prev && (i_ctl.lc_byte == i_tok_char);
    assign o_hit   = i_ctl.shift && i_is_last && n_match;
    assign o_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.clear) begin
            r_match <= 1'b0;
        end else if (i_ctl.shift) begin
            r_match <= n_match;
        end
    end

endmodule
`default_nettype wire

[rtl/hts_ctrl.sv]
`default_nettype none
// Line parser: name compare, colon and blank handling, found flag.
module hts_ctrl #(
    parameter int NAME_MAX = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_acc,
    input  wire logic [7:0]                      i_data,
    input  wire logic                            i_last,
    input  wire logic [8*hts_pkg::REG_CHARS-1:0] i_name_word,
    input  wire logic [hts_pkg::LEN_W-1:0]       i_name_len,
    input  wire logic                            i_tok_empty,
    input  wire logic                            i_hit,
    output hts_pkg::t_chain_ctl                  o_ctl,
    output hts_pkg::t_result                     o_res
);
    import hts_pkg::*;

    localparam int OW = $clog2(NAME_MAX + 2);

    localparam logic [1:0] PH_NAME   = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_IGNORE = 2'd3;

    logic [OW-1:0] r_offset, n_offset;
    logic          r_name_ok, n_name_ok;
    logic [1:0]    r_phase, n_phase;
    logic          r_after_nl, n_after_nl;
    logic          r_found, n_found;

    logic [7:0] w_lc;
    logic [7:0] w_name_char;
    logic [3:0] w_idx;
    logic       w_drop_cr;
    logic       w_is_nl;
    logic       w_push;
    logic       w_colon_hit;
    logic       w_found_now;

    assign w_lc      = to_lower(i_data);
    assign w_idx     = 4'(r_offset);
    assign w_drop_cr = r_after_nl && (i_data == CH_CR);
    assign w_is_nl   = (i_data == CH_LF);

    always_comb begin
        if (32'(r_offset) < REG_CHARS) begin
            w_name_char = to_lower(i_name_word[{w_idx, 3'b000} +: 8]);
        end else begin
            w_name_char = 8'h00;
        end
    end

    always_comb begin
        n_offset    = r_offset;
        n_name_ok   = r_name_ok;
        n_phase     = r_phase;
        n_after_nl  = r_after_nl;
        n_found     = r_found;
        w_push      = 1'b0;
        w_colon_hit = 1'b0;
        if (i_acc) begin
            n_after_nl = 1'b0;
            if (!w_drop_cr) begin
                if (w_is_nl) begin
                    n_offset   = '0;
                    n_name_ok  = 1'b1;
                    n_phase    = PH_NAME;
                    n_after_nl = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_NAME: begin
                            if (i_data == CH_COLON) begin
                                if (r_name_ok && (32'(i_name_len) <= NAME_MAX) &&
                                    (32'(r_offset) == 32'(i_name_len))) begin
                                    n_phase     = PH_SKIP;
                                    w_colon_hit = i_tok_empty;
                                end else begin
                                    n_phase = PH_IGNORE;
                                end
                            end else begin
                                if ((32'(r_offset) >= 32'(i_name_len)) ||
                                    (w_lc != w_name_char)) begin
                                    n_name_ok = 1'b0;
                                end
                                // saturate just past the longest legal name
                                if (32'(r_offset) < NAME_MAX + 1) begin
                                    n_offset = r_offset + OW'(1);
                                end
                            end
                        end
                        PH_SKIP: begin
                            if (i_data != CH_SPACE && i_data != CH_TAB) begin
                                n_phase = PH_VALUE;
                                w_push  = 1'b1;
                            end
                        end
                        PH_VALUE: begin
                            w_push = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (i_last) begin
                n_offset   = '0;
                n_name_ok  = 1'b1;
                n_phase    = PH_NAME;
                n_after_nl = 1'b0;
                n_found    = 1'b0;
            end else begin
                n_found = w_found_now;
            end
        end
    end

    assign w_found_now = r_found || w_colon_hit || i_hit;

    assign o_ctl.shift   = w_push;
    assign o_ctl.clear   = i_acc && ((!w_drop_cr && w_is_nl) || i_last);
    assign o_ctl.lc_byte = w_lc;

    assign o_res.valid = i_acc && i_last;
    assign o_res.found = w_found_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_name_ok  <= 1'b1;
            r_phase    <= PH_NAME;
            r_after_nl <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_offset   <= n_offset;
            r_name_ok  <= n_name_ok;
            r_phase    <= n_phase;
            r_after_nl <= n_after_nl;
            r_found    <= n_found;
        end
    end

endmodule
`default_nettype wire
